/* rtl/tps_pkg.sv */
// shared constants and helpers for the timer prescaler search
`timescale 1ns / 1ps

package tps_pkg;

    // word field widths
    localparam int PERIOD_W = 32;
    localparam int SEL_W    = 2;
    localparam int CS_W     = 3;
    localparam int TOP_W    = 16;

    // 20 * period needs five more bits than the period
    localparam int SCALED_W = PERIOD_W + 5;

    // number of prescaler divisors and index width
    localparam int DIV_COUNT = 5;
    localparam int DIV_IDX_W = 3;

    // divisor * top stays below 1024 * 65536
    localparam int PROD_W = 26;

    // reciprocal of 5 scaled by 2^26, exact for dividends below 2^26
    localparam int          RECIP_SHIFT = 26;
    localparam int          QUOT_IN_W   = PROD_W - 2;
    localparam logic [23:0] RECIP_FIVE  = 24'hCCCCCD;

    // timer widths
    localparam logic [TOP_W-1:0] LIMIT_NARROW = 16'h00FF;
    localparam logic [TOP_W-1:0] LIMIT_WIDE   = 16'hFFFF;

    // timer select code for the 8-bit timer
    localparam logic [SEL_W-1:0] SEL_NARROW = 2'd0;

    // clock-select codes
    localparam logic [CS_W-1:0] CS_NONE    = 3'd0;
    localparam logic [CS_W-1:0] CS_DIV1    = 3'd1;
    localparam logic [CS_W-1:0] CS_DIV1024 = 3'd5;

    // log2 of each divisor 1, 8, 64, 256, 1024
    function automatic logic [3:0] div_shift(input logic [DIV_IDX_W-1:0] idx);
        logic [3:0] sh;
        begin
            case (idx)
                3'd0:    sh = 4'd0;
                3'd1:    sh = 4'd3;
                3'd2:    sh = 4'd6;
                3'd3:    sh = 4'd8;
                3'd4:    sh = 4'd10;
                default: sh = 4'd0;
            endcase
            return sh;
        end
    endfunction

endpackage

/* rtl/timer_prescaler_top_search.sv */
// timer prescaler and compare value search, top level
//
// Input channel: in_valid / in_stall carry one word holding period_us (target
// period in microseconds at 20 MHz) and timer_select (0 = 8-bit timer, other
// values = 16-bit timer). Output channel: out_valid / out_stall carry found,
// clock_select, compare_top and error_us for each input word, in order.
// An accepted word is held in the input register and then moves on into the
// result register, which drives the output channel.
// One word is accepted every cycle; the only limit is the receiver.
// The achieved period shrinks as the divisor grows, so the smallest divisor
// whose top fits the timer always gives the least error. One stage picks it
// and divides the truncated count by 20 through a 24 x 24 reciprocal multiply.
// When out_stall is high the result word holds; the input register keeps
// accepting until it too is full, and in_stall then follows out_stall.
// Reset clears both valid flags; no result is presented until a word enters.
`timescale 1ns / 1ps

module timer_prescaler_top_search
    import tps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [PERIOD_W-1:0] period_us,
    input  logic [SEL_W-1:0]    timer_select,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [CS_W-1:0]     clock_select,
    output logic [TOP_W-1:0]    compare_top,
    output logic [PERIOD_W-1:0] error_us
);

    logic                in_valid_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [SEL_W-1:0]    sel_reg;

    logic                out_valid_reg;
    logic                found_reg;
    logic [CS_W-1:0]     cs_reg;
    logic [TOP_W-1:0]    top_reg;
    logic [PERIOD_W-1:0] err_reg;

    logic                found_next;
    logic [CS_W-1:0]     cs_next;
    logic [TOP_W-1:0]    top_next;
    logic [PERIOD_W-1:0] err_next;

    logic adv_out;
    logic adv_in;

    logic [SCALED_W-1:0]   scaled;
    logic [TOP_W-1:0]      limit;
    logic [DIV_COUNT-1:0]  fits;
    logic [DIV_IDX_W-1:0]  pick;
    logic                  any_fit;
    logic [3:0]            pick_sh;
    logic [SCALED_W-1:0]   top_full;
    logic [PROD_W-1:0]     prod;
    logic [QUOT_IN_W-1:0]  quot_in;
    logic [47:0]           recip_prod;
    logic [PERIOD_W-1:0]   achieved;

    // pipeline advance
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_in   = !in_valid_reg || adv_out;
    assign in_stall = !adv_in;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv_in)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid)
        begin
            period_reg <= period_us;
            sel_reg    <= timer_select;
        end
    end

    // scaled count and timer limit
    assign scaled = ({5'd0, period_reg} << 4) + ({5'd0, period_reg} << 2);
    assign limit  = (sel_reg == SEL_NARROW) ? LIMIT_NARROW : LIMIT_WIDE;

    // feasibility of each divisor
    always_comb
    begin
        for (int k = 0; k < DIV_COUNT; k++)
        begin
            fits[k] = (scaled >> div_shift(DIV_IDX_W'(k))) <= {21'd0, limit};
        end
    end

    // smallest feasible divisor
    always_comb
    begin
        pick = DIV_IDX_W'(0);
        for (int k = DIV_COUNT - 1; k >= 0; k--)
        begin
            if (fits[k])
            begin
                pick = DIV_IDX_W'(k);
            end
        end
    end

    assign any_fit  = |fits;
    assign pick_sh  = div_shift(pick);
    assign top_full = scaled >> pick_sh;

    // achieved period: (top << shift) / 20 as ((.. >> 2) * recip(5)) >> 26
    assign prod       = PROD_W'(top_full[TOP_W-1:0]) << pick_sh;
    assign quot_in    = prod[PROD_W-1:2];
    assign recip_prod = quot_in * RECIP_FIVE;
    assign achieved   = PERIOD_W'(recip_prod[47:RECIP_SHIFT]);

    // result word
    always_comb
    begin
        if (any_fit)
        begin
            found_next = 1'b1;
            cs_next    = CS_W'(pick) + CS_DIV1;
            top_next   = top_full[TOP_W-1:0];
            err_next   = period_reg - achieved;
        end
        else
        begin
            found_next = 1'b0;
            cs_next    = CS_NONE;
            top_next   = '0;
            err_next   = '0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && in_valid_reg)
        begin
            found_reg <= found_next;
            cs_reg    <= cs_next;
            top_reg   <= top_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign clock_select = cs_reg;
    assign compare_top  = top_reg;
    assign error_us     = err_reg;

endmodule

/* rtl/tps_checker.sv */
// port-level checks for the timer prescaler search, bound to the top level
`timescale 1ns / 1ps

module tps_checker
    import tps_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                found,
    input logic [CS_W-1:0]     clock_select,
    input logic [TOP_W-1:0]    compare_top,
    input logic [PERIOD_W-1:0] error_us
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(clock_select)
            && $stable(compare_top) && $stable(error_us))
    else $error("stalled result word changed");

    // a word that finds nothing carries all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> clock_select == CS_NONE && compare_top == '0 && error_us == '0)
    else $error("empty result word not cleared");

    // a found word names a real prescaler
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> clock_select >= CS_DIV1 && clock_select <= CS_DIV1024)
    else $error("clock select out of range");

    // divide by one is always exact
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found && clock_select == CS_DIV1 |-> error_us == '0)
    else $error("nonzero error with undivided clock");

    // a fresh result traces back to an accepted input word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without input word");

endmodule

bind timer_prescaler_top_search tps_checker u_tps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .clock_select (clock_select),
    .compare_top  (compare_top),
    .error_us     (error_us)
);
